@@ rtl/core/xcpr_pkg.sv @@
// Package with the types and constants shared by the packet receiver modules.
package xcpr_pkg;

  localparam logic [7:0] StartByte = 8'hA1;
  localparam int unsigned TypeShift = 6;
  localparam int unsigned LenWidth = 6;
  localparam int unsigned CountWidth = LenWidth + 1;

  typedef enum logic [2:0] {
    EvIgnored = 3'd0,
    EvStart   = 3'd1,
    EvHeader  = 3'd2,
    EvPayload = 3'd3,
    EvDone    = 3'd4
  } xcpr_event_e;

  typedef enum logic [1:0] {
    FtHandshake = 2'd0,
    FtAckNack   = 2'd1,
    FtRequest   = 2'd2,
    FtData      = 2'd3
  } xcpr_ftype_e;

  typedef enum logic [1:0] {
    RpNone   = 2'd0,
    RpAck    = 2'd1,
    RpNack   = 2'd2,
    RpAckHdr = 2'd3
  } xcpr_reply_e;

  localparam logic [1:0] AnvInvalid = 2'd2;
  localparam logic [1:0] AnvAck     = 2'd1;

  typedef struct packed {
    xcpr_event_e         event_res;
    xcpr_ftype_e         frame_type;
    logic [LenWidth-1:0] frame_length;
    logic [7:0]          payload_byte;
    logic [LenWidth-1:0] payload_index;
    logic                checksum_ok;
    xcpr_reply_e         reply;
    logic                handshake_established;
    logic [1:0]          ack_nack_value;
    logic                handling_request_now;
    logic [7:0]          request_value;
  } xcpr_result_t;

endpackage

@@ rtl/core/xcpr_in_stage.sv @@
// Input register that holds one received byte until the deframer takes it.
module xcpr_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;

  assign rx_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (rx_valid_i && rx_ready_o) begin
      valid_d = 1'b1;
      byte_d  = rx_byte_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

@@ rtl/core/xcpr_deframer.sv @@
// Frame state, running checksum and protocol reaction for one byte per step.
module xcpr_deframer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output xcpr_pkg::xcpr_result_t res_o
);
  import xcpr_pkg::*;

  logic                  in_frame_q, in_frame_d;
  logic [CountWidth-1:0] count_q, count_d;
  xcpr_ftype_e           type_q, type_d;
  logic [LenWidth-1:0]   len_q, len_d;
  logic [7:0]            xor_q, xor_d;
  logic [7:0]            first_q, first_d;
  logic                  hs_up_q, hs_up_d;
  logic                  handling_q, handling_d;
  logic [7:0]            req_q, req_d;
  logic [CountWidth-1:0] idx;
  logic                  good;

  assign idx  = count_q - CountWidth'(1);
  assign good = (xor_q == byte_i);

  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    type_d     = type_q;
    len_d      = len_q;
    xor_d      = xor_q;
    first_d    = first_q;
    hs_up_d    = hs_up_q;
    handling_d = handling_q;
    req_d      = req_q;
    res_o      = '0;
    res_o.event_res  = EvIgnored;
    res_o.frame_type = FtHandshake;
    res_o.reply      = RpNone;

    if (!in_frame_q && byte_i == StartByte) begin
      in_frame_d      = 1'b1;
      count_d         = '0;
      res_o.event_res = EvStart;
    end else if (in_frame_q && count_q == ({1'b0, len_q} + CountWidth'(1))) begin
      in_frame_d         = 1'b0;
      count_d            = '0;
      res_o.event_res    = EvDone;
      res_o.frame_type   = type_q;
      res_o.frame_length = len_q;
      res_o.checksum_ok  = good;
      if (hs_up_q || type_q == FtHandshake) begin
        case (type_q)
          FtHandshake: begin
            hs_up_d     = good;
            res_o.reply = good ? RpAckHdr : RpNack;
          end
          FtAckNack: begin
            if (good) begin
              res_o.ack_nack_value = (first_q > 8'd1) ? AnvInvalid : first_q[1:0];
            end else begin
              res_o.ack_nack_value = AnvInvalid;
              res_o.reply          = RpNack;
            end
          end
          FtRequest: begin
            res_o.ack_nack_value = AnvAck;
            if (good) begin
              req_d       = first_q;
              handling_d  = 1'b1;
              res_o.reply = RpAck;
            end else begin
              res_o.reply = RpNack;
            end
          end
          default: begin
            res_o.reply = good ? RpAck : RpNack;
          end
        endcase
      end
    end else if (in_frame_q && count_q != '0) begin
      if (idx == '0) begin
        first_d = byte_i;
      end
      xor_d               = xor_q ^ byte_i;
      count_d             = count_q + CountWidth'(1);
      res_o.event_res     = EvPayload;
      res_o.frame_type    = type_q;
      res_o.frame_length  = len_q;
      res_o.payload_byte  = byte_i;
      res_o.payload_index = idx[LenWidth-1:0];
    end else if (in_frame_q) begin
      count_d            = CountWidth'(1);
      type_d             = xcpr_ftype_e'(byte_i[7:TypeShift]);
      len_d              = byte_i[LenWidth-1:0];
      xor_d              = '0;
      first_d            = '0;
      res_o.event_res    = EvHeader;
      res_o.frame_type   = type_d;
      res_o.frame_length = len_d;
    end

    res_o.handshake_established = hs_up_d;
    res_o.handling_request_now  = handling_d;
    res_o.request_value         = req_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
      type_q     <= FtHandshake;
      len_q      <= '0;
      xor_q      <= '0;
      first_q    <= '0;
      hs_up_q    <= 1'b0;
      handling_q <= 1'b0;
      req_q      <= '0;
    end else if (step_i) begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      type_q     <= type_d;
      len_q      <= len_d;
      xor_q      <= xor_d;
      first_q    <= first_d;
      hs_up_q    <= hs_up_d;
      handling_q <= handling_d;
      req_q      <= req_d;
    end
  end

endmodule

@@ rtl/core/xcpr_out_stage.sv @@
// Result register that holds one result until the receiving side takes it.
module xcpr_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  xcpr_pkg::xcpr_result_t res_i,
  output logic                  free_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output xcpr_pkg::xcpr_result_t res_o
);
  import xcpr_pkg::*;

  logic         valid_q, valid_d;
  xcpr_result_t res_q, res_d;

  assign free_o = !valid_q || res_ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (res_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/core/xor_checked_packet_receiver_unit.sv @@
// Path: a request byte is registered in the input stage, stepped through the deframer
// when the result register is free, and its result is held in the result register.
// Rate: one request per cycle while res_ready_i keeps the result register free; the
// deframer's frame state loop updates on each step, so bytes may follow back to back.
// Reset: rst_ni clears all frame and protocol state and empties both stages.
module xor_checked_packet_receiver_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic [2:0] event_res_o,
  output logic [1:0] frame_type_o,
  output logic [5:0] frame_length_o,
  output logic [7:0] payload_byte_o,
  output logic [5:0] payload_index_o,
  output logic       checksum_ok_o,
  output logic [1:0] reply_o,
  output logic       handshake_established_o,
  output logic [1:0] ack_nack_value_o,
  output logic       handling_request_now_o,
  output logic [7:0] request_value_o
);
  import xcpr_pkg::*;

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         out_free;
  logic         step;
  xcpr_result_t step_res;
  xcpr_result_t out_res;

  assign step = in_valid && out_free;

  xcpr_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (step),
    .valid_o    (in_valid),
    .byte_o     (in_byte)
  );

  xcpr_deframer u_deframer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte),
    .res_o  (step_res)
  );

  xcpr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (step_res),
    .free_o      (out_free),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .res_o       (out_res)
  );

  assign event_res_o             = out_res.event_res;
  assign frame_type_o            = out_res.frame_type;
  assign frame_length_o          = out_res.frame_length;
  assign payload_byte_o          = out_res.payload_byte;
  assign payload_index_o         = out_res.payload_index;
  assign checksum_ok_o           = out_res.checksum_ok;
  assign reply_o                 = out_res.reply;
  assign handshake_established_o = out_res.handshake_established;
  assign ack_nack_value_o        = out_res.ack_nack_value;
  assign handling_request_now_o  = out_res.handling_request_now;
  assign request_value_o         = out_res.request_value;

endmodule
